/* design/nfvs_pkg.sv */
`timescale 1ns / 1ps
package nfvs_pkg;
    typedef struct packed {
        logic       opcode;
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic [4:0] cell_z;
        logic       cell_free;
        logic [5:0] reach;
    } in_item_t;

    typedef struct packed {
        logic       found;
        logic [4:0] free_x;
        logic [4:0] free_y;
        logic [4:0] free_z;
    } out_item_t;

    // cells per axis held in storage
    localparam int SIDE = 32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam logic [5:0] SIDE_RESET = 6'd20;
endpackage

/* design/nearest_free_voxel_search_core.sv */
`timescale 1ns / 1ps
// channel | direction | payload    | handshake
// in      | input     | in_item_t  | in_valid / in_ready
// out     | output    | out_item_t | out_valid / out_ready
// cfg     | input     | grid_side  | cfg_we, no wait
//
// writes stream one per cycle while the core is idle, also while a result waits
// a query with a free start, or reach 0 or 1, ends on the read of its start cell
// else one read per visited cell, V = sum over s = 1..reach-1 of 2*(2s-1)^2 + 4*(2s+1)^2;
//   a miss ends after the last shell is read, a hit once a read finds a free cell
// the next transfer can come once the done step has passed; a query waits in its start step
//   while an earlier result is not taken; after reset a pass marks all 32768 cells free
module nearest_free_voxel_search_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [5:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  nfvs_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output nfvs_pkg::out_item_t  out_data
);
    import nfvs_pkg::*;

    localparam int CW    = $clog2(SIDE);
    localparam int AW    = 3 * CW;
    localparam int DEPTH = SIDE * SIDE * SIDE;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // grid memory, one bit per cell
    logic mem [DEPTH];
    logic rd_data_reg;

    logic [2:0]    state_reg, state_next;
    logic [AW:0]   clr_cnt_reg;
    logic [5:0]    side_reg;
    logic signed [7:0] sx_reg, sy_reg, sz_reg;
    logic [5:0]    reach_reg;
    logic [5:0]    s_reg;
    logic [2:0]    ph_reg;
    logic signed [7:0] a_reg, b_reg;
    logic signed [7:0] cx_reg, cy_reg, cz_reg;
    logic          cin_reg;
    logic          end_reg;
    logic          rd_pend_reg;
    logic          out_valid_reg;
    out_item_t     out_reg;
    logic [6:0]    act;

    // active side, clamped to 1..SIDE
    always_comb
    begin
        if (side_reg == 6'd0)
            act = 7'd1;
        else if (32'(side_reg) > SIDE)
            act = 7'(SIDE);
        else
            act = {1'b0, side_reg};
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    logic in_xfer;
    assign in_xfer = in_valid && in_ready;

    // candidate cell for the current scan point
    logic signed [7:0] px, py, pz;
    logic signed [7:0] sn;
    always_comb
    begin
        sn = $signed({2'b00, s_reg});
        px = sx_reg; py = sy_reg; pz = sz_reg;
        case (ph_reg)
            3'd0: begin px = sx_reg - sn; py = sy_reg + a_reg; pz = sz_reg + b_reg; end
            3'd1: begin px = sx_reg + sn; py = sy_reg + a_reg; pz = sz_reg + b_reg; end
            3'd2: begin px = sx_reg + a_reg; py = sy_reg + b_reg; pz = sz_reg - sn; end
            3'd3: begin px = sx_reg + a_reg; py = sy_reg + b_reg; pz = sz_reg + sn; end
            3'd4: begin px = sx_reg + a_reg; py = sy_reg + sn; pz = sz_reg + b_reg; end
            3'd5: begin px = sx_reg + a_reg; py = sy_reg - sn; pz = sz_reg + b_reg; end
            default: begin px = sx_reg; py = sy_reg; pz = sz_reg; end
        endcase
    end

    logic p_in;
    assign p_in = (px >= 0) && (py >= 0) && (pz >= 0) &&
                  (px < $signed({1'b0, act})) && (py < $signed({1'b0, act})) &&
                  (pz < $signed({1'b0, act}));

    // step to the next scan point
    logic signed [7:0] na, nb;
    logic [2:0] nph;
    logic [5:0] ns;
    logic       scan_end;
    always_comb
    begin
        na = a_reg; nb = b_reg; nph = ph_reg; ns = s_reg; scan_end = 1'b0;
        if (ph_reg <= 3'd1) begin
            if (b_reg < sn - 8'sd1)
                nb = b_reg + 8'sd1;
            else if (a_reg < sn - 8'sd1) begin
                na = a_reg + 8'sd1; nb = -sn + 8'sd1;
            end else if (ph_reg == 3'd0) begin
                nph = 3'd1; na = -sn + 8'sd1; nb = -sn + 8'sd1;
            end else begin
                nph = 3'd2; na = -sn; nb = -sn;
            end
        end else begin
            if (ph_reg < 3'd5)
                nph = ph_reg + 3'd1;
            else begin
                nph = 3'd2;
                if (b_reg < sn)
                    nb = b_reg + 8'sd1;
                else if (a_reg < sn) begin
                    na = a_reg + 8'sd1; nb = -sn;
                end else begin
                    ns = s_reg + 6'd1;
                    nph = 3'd0;
                    na = -$signed({2'b00, ns}) + 8'sd1;
                    nb = -$signed({2'b00, ns}) + 8'sd1;
                    if ({1'b0, ns} >= {1'b0, reach_reg})
                        scan_end = 1'b1;
                end
            end
        end
    end

    // memory address muxing
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic          mem_re;
    logic          wr_ok;

    assign wr_ok = (32'(in_data.cell_x) < SIDE) && (32'(in_data.cell_y) < SIDE) &&
                   (32'(in_data.cell_z) < SIDE);

    always_comb
    begin
        mem_we = 1'b0; mem_waddr = '0; mem_wdata = 1'b1;
        if (state_reg == ST_CLEAR) begin
            mem_we = 1'b1; mem_waddr = clr_cnt_reg[AW-1:0];
        end else if (in_xfer && in_data.opcode == OP_WRITE && wr_ok) begin
            mem_we = 1'b1;
            mem_waddr = {in_data.cell_x[CW-1:0], in_data.cell_y[CW-1:0],
                         in_data.cell_z[CW-1:0]};
            mem_wdata = in_data.cell_free;
        end
    end

    always_comb
    begin
        mem_re = 1'b0; mem_raddr = '0;
        if (state_reg == ST_START) begin
            mem_re = 1'b1;
            mem_raddr = {sx_reg[CW-1:0], sy_reg[CW-1:0], sz_reg[CW-1:0]};
        end else if (state_reg == ST_SCAN) begin
            mem_re = 1'b1;
            mem_raddr = {px[CW-1:0], py[CW-1:0], pz[CW-1:0]};
        end
    end

    // grid memory port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    logic hit;
    assign hit = rd_pend_reg && cin_reg && rd_data_reg;

    // state sequencing
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == (AW+1)'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (in_xfer && in_data.opcode == OP_QUERY) state_next = ST_START;
            ST_START: if (!out_valid_reg || out_ready) state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (hit)
                    state_next = ST_DONE;
                else if ((s_reg == 6'd0) && (reach_reg <= 6'd1))
                    state_next = ST_DONE;
                else if (end_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control and scan registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            side_reg      <= SIDE_RESET;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cfg_we)
                side_reg <= cfg_data;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            rd_pend_reg <= mem_re && !(state_reg == ST_SCAN && state_next == ST_DONE);
            if (state_reg == ST_SCAN && state_next == ST_DONE)
                out_valid_reg <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            sx_reg    <= $signed({3'b000, in_data.cell_x});
            sy_reg    <= $signed({3'b000, in_data.cell_y});
            sz_reg    <= $signed({3'b000, in_data.cell_z});
            reach_reg <= in_data.reach;
        end
        if (state_reg == ST_START) begin
            cin_reg <= (sx_reg < $signed({1'b0, act})) && (sy_reg < $signed({1'b0, act})) &&
                       (sz_reg < $signed({1'b0, act}));
            s_reg   <= 6'd0;
            ph_reg  <= 3'd0;
            end_reg <= 1'b0;
            cx_reg <= sx_reg; cy_reg <= sy_reg; cz_reg <= sz_reg;
            a_reg  <= 8'sd0; b_reg <= 8'sd0;
        end else if (state_reg == ST_SCAN) begin
            cin_reg <= p_in;
            cx_reg  <= px; cy_reg <= py; cz_reg <= pz;
            if (s_reg == 6'd0) begin
                s_reg   <= 6'd1;
                ph_reg  <= 3'd0;
                end_reg <= 1'b0;
                a_reg   <= 8'sd0; b_reg <= 8'sd0;
            end else begin
                // last read of the last shell is still checked in the next cycle
                end_reg <= scan_end;
                s_reg <= ns; ph_reg <= nph; a_reg <= na; b_reg <= nb;
            end
        end
        if (state_reg == ST_SCAN && state_next == ST_DONE) begin
            out_reg.found  <= hit;
            out_reg.free_x <= hit ? cx_reg[4:0] : sx_reg[4:0];
            out_reg.free_y <= hit ? cy_reg[4:0] : sy_reg[4:0];
            out_reg.free_z <= hit ? cz_reg[4:0] : sz_reg[4:0];
        end
    end

    // checks
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !in_ready) else $error("input taken during scan");
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg) else $error("result during clear");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(out_reg)) else $error("result changed");
endmodule
